// ===== src/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types, codes and constants of the cosine best-match table.
// ----------------------------------------------------------------------------
package cbm_pkg;

    localparam int CBM_EMBED_DIM   = 512;
    localparam int CBM_MAX_ENTRIES = 64;

    localparam int ELEM_W  = 16;
    localparam int LABEL_W = 16;
    localparam int ENTRY_W = 6;
    localparam int SIM_W   = 16;
    localparam int CFG_ADDR_W = 3;

    // Word index of the threshold register (paddr bit 2).
    localparam logic REG_THRESHOLD = 1'b0;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_TMPL  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [2:0] ST_KNOWN   = 3'd0;
    localparam logic [2:0] ST_UNKNOWN = 3'd1;
    localparam logic [2:0] ST_STORED  = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_BADLEN  = 3'd4;

    localparam logic signed [SIM_W-1:0] SIM_NONE = 16'sh8000;
    localparam logic signed [SIM_W-1:0] SIM_MAX  = 16'sh7FFF;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [ELEM_W-1:0] element_value;
        logic [LABEL_W-1:0]       template_label;
        logic                     element_last;
    } t_item;

    typedef struct packed {
        logic [2:0]              status;
        logic [ENTRY_W-1:0]      best_entry;
        logic [LABEL_W-1:0]      best_label;
        logic signed [SIM_W-1:0] best_similarity;
    } t_result;

endpackage

// ===== src/cosine_best_match_table.sv =====
// ----------------------------------------------------------------------------
// cosine_best_match_table
// Labelled embedding table with a best-match lookup by cosine similarity.
// ----------------------------------------------------------------------------
// Use: drive i_item and raise start; the beat is taken when busy is low.
// A clear, and any element that is not marked last, gives no result, so
// such beats can follow each other every cycle.
// A last template element of the wrong length, or one for a full table,
// gives its result on the next cycle. A good template is committed by a
// sweep over its stored elements to form its norm.
// A last query element starts the scoring: each stored entry costs one
// pass over the template memory (one element read per cycle) plus a run
// of the score unit, cut short for a zero norm. A query of the wrong
// length, or one for an empty table, goes straight to its result.
// Each result appears on o_result, marked by o_done for one cycle; there is
// no back-pressure. busy stays high from a committed template or a last
// query element until its result.
// The user writes the threshold register over the APB port only while idle;
// the block does not enforce it. Reset empties the table and zeroes the threshold;
// the memories are not cleared, as no entry is read before it is written.
// ----------------------------------------------------------------------------
module cosine_best_match_table
    import cbm_pkg::*;
#(
    parameter int EMBED_DIM   = CBM_EMBED_DIM,
    parameter int MAX_ENTRIES = CBM_MAX_ENTRIES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_item                 i_item,
    output logic                  o_done,
    output t_result               o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int IDX_W  = $clog2(EMBED_DIM);
    localparam int CNT_W  = $clog2(EMBED_DIM + 1);
    localparam int ECW    = $clog2(MAX_ENTRIES + 1);
    localparam int ENT_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int DEPTH  = MAX_ENTRIES * EMBED_DIM;
    localparam int TA_W   = $clog2(DEPTH);
    localparam int NORM_W = 31 + IDX_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TNORM = 3'd1;
    localparam logic [2:0] S_QDOT  = 3'd2;
    localparam logic [2:0] S_SCORE = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    // Memories.
    logic signed [ELEM_W-1:0] tmem [DEPTH];
    logic signed [ELEM_W-1:0] qmem [EMBED_DIM];
    logic [NORM_W-1:0]        nmem [MAX_ENTRIES];
    logic [LABEL_W-1:0]       lmem [MAX_ENTRIES];

    logic [2:0]               r_state;
    logic [CNT_W-1:0]         r_cnt;
    logic [ECW-1:0]           r_ec;
    logic [TA_W-1:0]          r_wbase, r_rbase;
    logic [ENT_W-1:0]         r_ent;
    logic [LABEL_W-1:0]       r_label;
    logic                     r_issue, r_v1, r_v2;
    logic [IDX_W-1:0]         r_idx;
    logic signed [ELEM_W-1:0] r_t_rd, r_q_rd;
    logic [NORM_W-1:0]        r_tn_rd;
    logic [LABEL_W-1:0]       r_lab_rd;
    logic signed [31:0]       r_pd;
    logic [30:0]              r_pn;
    logic signed [NORM_W:0]   r_dot;
    logic [NORM_W-1:0]        r_nacc, r_qn;
    logic                     r_sc_start;
    logic signed [SIM_W-1:0]  r_best;
    logic [ENT_W-1:0]         r_best_ent;
    logic [LABEL_W-1:0]       r_best_lab;
    logic                     r_done;
    t_result                  r_res;

    logic                     accept, pos_in, len_ok, ec_ok, pass_done;
    logic                     t_we, q_we, commit;
    logic [TA_W-1:0]          t_waddr;
    logic signed [ELEM_W-1:0] sq_sel;
    logic signed [31:0]       sq;
    logic                     sc_done;
    logic signed [SIM_W-1:0]  sc_score;
    logic signed [SIM_W-1:0]  threshold;

    cbm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_threshold (threshold)
    );

    cbm_score #(
        .NORM_W (NORM_W)
    ) u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sc_start),
        .i_dot   (r_dot),
        .i_qn    (r_qn),
        .i_tn    (r_tn_rd),
        .o_done  (sc_done),
        .o_score (sc_score)
    );

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign pos_in    = (r_cnt < CNT_W'(EMBED_DIM));
    assign len_ok    = (r_cnt == CNT_W'(EMBED_DIM - 1));
    assign ec_ok     = (r_ec < ECW'(MAX_ENTRIES));
    assign pass_done = !r_issue && !r_v1 && !r_v2;
    assign t_we      = accept && (i_item.kind == KIND_TMPL) && pos_in && ec_ok;
    assign q_we      = accept && (i_item.kind == KIND_QUERY) && pos_in;
    assign t_waddr   = r_wbase + TA_W'(r_cnt[IDX_W-1:0]);
    assign commit    = (r_state == S_TNORM) && pass_done;

    // Template sweeps square the template element, query passes the query element.
    assign sq_sel = (r_state == S_TNORM) ? r_t_rd : r_q_rd;
    assign sq     = sq_sel * sq_sel;

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            tmem[t_waddr] <= i_item.element_value;
        end
        if (r_issue) begin
            r_t_rd <= tmem[r_rbase + TA_W'(r_idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            qmem[r_cnt[IDX_W-1:0]] <= i_item.element_value;
        end
        if (r_issue) begin
            r_q_rd <= qmem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            nmem[r_ec[ENT_W-1:0]] <= r_nacc;
            lmem[r_ec[ENT_W-1:0]] <= r_label;
        end
        r_tn_rd  <= nmem[r_ent];
        r_lab_rd <= lmem[r_ent];
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_pd <= r_q_rd * r_t_rd;
            r_pn <= sq[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_ec       <= '0;
            r_wbase    <= '0;
            r_issue    <= 1'b0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_done     <= 1'b0;
            r_sc_start <= 1'b0;
        end else begin
            r_done     <= 1'b0;
            r_sc_start <= 1'b0;
            r_v1       <= r_issue;
            r_v2       <= r_v1;
            if (r_issue) begin
                if (r_idx == IDX_W'(EMBED_DIM - 1)) begin
                    r_issue <= 1'b0;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            if (r_v2) begin
                r_dot  <= r_dot + (NORM_W + 1)'(r_pd);
                r_nacc <= r_nacc + NORM_W'(r_pn);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_item.kind) inside
                            KIND_CLEAR: begin
                                r_ec    <= '0;
                                r_cnt   <= '0;
                                r_wbase <= '0;
                            end
                            KIND_TMPL, KIND_QUERY: begin
                                if (!i_item.element_last) begin
                                    if (pos_in) begin
                                        r_cnt <= r_cnt + CNT_W'(1);
                                    end
                                end else begin
                                    r_cnt <= '0;
                                    if (i_item.kind == KIND_TMPL) begin
                                        r_res.best_entry      <= '0;
                                        r_res.best_label      <= '0;
                                        r_res.best_similarity <= SIM_NONE;
                                        if (!len_ok) begin
                                            r_res.status <= ST_BADLEN;
                                            r_done       <= 1'b1;
                                        end else if (!ec_ok) begin
                                            r_res.status <= ST_FULL;
                                            r_done       <= 1'b1;
                                        end else begin
                                            r_label <= i_item.template_label;
                                            r_rbase <= r_wbase;
                                            r_issue <= 1'b1;
                                            r_idx   <= '0;
                                            r_nacc  <= '0;
                                            r_dot   <= '0;
                                            r_state <= S_TNORM;
                                        end
                                    end else begin
                                        r_best     <= SIM_NONE;
                                        r_best_ent <= '0;
                                        r_best_lab <= '0;
                                        r_ent      <= '0;
                                        if (len_ok && r_ec != '0) begin
                                            r_rbase <= '0;
                                            r_issue <= 1'b1;
                                            r_idx   <= '0;
                                            r_nacc  <= '0;
                                            r_dot   <= '0;
                                            r_state <= S_QDOT;
                                        end else begin
                                            r_state <= S_FIN;
                                        end
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_TNORM: begin
                    if (pass_done) begin
                        r_res.status          <= ST_STORED;
                        r_res.best_entry      <= ENTRY_W'(r_ec);
                        r_res.best_label      <= r_label;
                        r_res.best_similarity <= SIM_NONE;
                        r_done  <= 1'b1;
                        r_ec    <= r_ec + ECW'(1);
                        r_wbase <= r_wbase + TA_W'(EMBED_DIM);
                        r_state <= S_IDLE;
                    end
                end
                S_QDOT: begin
                    if (pass_done) begin
                        // The first pass also forms the query norm.
                        if (r_ent == '0) begin
                            r_qn <= r_nacc;
                        end
                        r_sc_start <= 1'b1;
                        r_state    <= S_SCORE;
                    end
                end
                S_SCORE: begin
                    if (sc_done) begin
                        if (sc_score > r_best) begin
                            r_best     <= sc_score;
                            r_best_ent <= r_ent;
                            r_best_lab <= r_lab_rd;
                        end
                        if (ECW'(r_ent) + ECW'(1) == r_ec) begin
                            r_state <= S_FIN;
                        end else begin
                            r_ent   <= r_ent + ENT_W'(1);
                            r_rbase <= r_rbase + TA_W'(EMBED_DIM);
                            r_issue <= 1'b1;
                            r_idx   <= '0;
                            r_nacc  <= '0;
                            r_dot   <= '0;
                            r_state <= S_QDOT;
                        end
                    end
                end
                S_FIN: begin
                    r_res.best_entry      <= ENTRY_W'(r_best_ent);
                    r_res.best_similarity <= r_best;
                    if (r_ec != '0 && r_best >= threshold) begin
                        r_res.status     <= ST_KNOWN;
                        r_res.best_label <= r_best_lab;
                    end else begin
                        r_res.status     <= ST_UNKNOWN;
                        r_res.best_label <= '0;
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ===== src/cbm_cfg.sv =====
// ----------------------------------------------------------------------------
// cbm_cfg
// APB register file holding the match threshold.
// ----------------------------------------------------------------------------
module cbm_cfg
    import cbm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    output logic signed [SIM_W-1:0] o_threshold
);

    logic signed [SIM_W-1:0] r_threshold;
    logic                    hit;

    assign hit    = (paddr[2] == REG_THRESHOLD);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (psel && penable && pwrite && hit) begin
            r_threshold <= pwdata[SIM_W-1:0];
        end
    end

    assign prdata      = hit ? {{(32-SIM_W){r_threshold[SIM_W-1]}}, r_threshold} : 32'd0;
    assign o_threshold = r_threshold;

endmodule

// ===== src/cbm_score.sv =====
// ----------------------------------------------------------------------------
// cbm_score
// Turns a dot product and two squared norms into a Q1.15 cosine score.
// Products are built from half-width partial products, then a bit-serial
// square root search finds the largest s with den * s^2 <= dot^2 << 30.
// ----------------------------------------------------------------------------
module cbm_score
    import cbm_pkg::*;
#(
    parameter int NORM_W = 40
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NORM_W:0]  i_dot,
    input  logic [NORM_W-1:0]       i_qn,
    input  logic [NORM_W-1:0]       i_tn,
    output logic                    o_done,
    output logic signed [SIM_W-1:0] o_score
);

    localparam int H     = (NORM_W + 1) / 2;
    localparam int PW    = NORM_W + H;
    localparam int DEN_W = 2 * NORM_W;
    localparam int RHS_W = 2 * NORM_W + 30;
    localparam int AW    = RHS_W + 2;

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_M0   = 3'd1;
    localparam logic [2:0] C_M1   = 3'd2;
    localparam logic [2:0] C_M2   = 3'd3;
    localparam logic [2:0] C_M3   = 3'd4;
    localparam logic [2:0] C_SQ   = 3'd5;
    localparam logic [2:0] C_OUT  = 3'd6;

    logic [2:0]              r_state;
    logic [NORM_W-1:0]       r_qn, r_tn, r_mag;
    logic                    r_neg;
    logic [DEN_W-1:0]        r_den;
    logic [RHS_W-1:0]        r_rhs;
    logic [AW-1:0]           r_s, r_e, r_d;
    logic [15:0]             r_lo;
    logic [3:0]              r_bit;
    logic                    r_done;
    logic signed [SIM_W-1:0] r_score;

    logic [NORM_W-1:0] mul_a;
    logic [H-1:0]      mul_b;
    logic [PW-1:0]     prod;
    logic [AW-1:0]     trial;
    logic              fits;
    logic signed [NORM_W:0] dot_abs;

    always_comb begin
        mul_a = r_mag;
        mul_b = r_mag[H-1:0];
        case (r_state)
            C_M0: begin
                mul_a = r_qn;
                mul_b = r_tn[H-1:0];
            end
            C_M1: begin
                mul_a = r_qn;
                mul_b = H'(r_tn[NORM_W-1:H]);
            end
            C_M3: begin
                mul_b = H'(r_mag[NORM_W-1:H]);
            end
            default: begin
            end
        endcase
    end

    assign prod    = PW'(mul_a) * PW'(mul_b);
    assign trial   = r_s + r_e + r_d;
    assign fits    = (trial <= AW'(r_rhs));
    assign dot_abs = i_dot[NORM_W] ? -i_dot : i_dot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_qn  <= i_qn;
                        r_tn  <= i_tn;
                        r_neg <= i_dot[NORM_W];
                        r_mag <= dot_abs[NORM_W-1:0];
                        if (i_qn == '0 || i_tn == '0) begin
                            r_score <= SIM_NONE;
                            r_done  <= 1'b1;
                        end else begin
                            r_state <= C_M0;
                        end
                    end
                end
                C_M0: begin
                    r_den   <= DEN_W'(prod);
                    r_state <= C_M1;
                end
                C_M1: begin
                    r_den   <= r_den + (DEN_W'(prod) << H);
                    r_state <= C_M2;
                end
                C_M2: begin
                    r_rhs   <= RHS_W'(prod);
                    r_state <= C_M3;
                end
                C_M3: begin
                    r_rhs   <= (r_rhs + (RHS_W'(prod) << H)) << 30;
                    r_d     <= AW'(r_den) << 30;
                    r_e     <= '0;
                    r_s     <= '0;
                    r_lo    <= '0;
                    r_bit   <= 4'd15;
                    r_state <= C_SQ;
                end
                C_SQ: begin
                    // r_e tracks den*lo shifted by (bit+1), r_d tracks den shifted by 2*bit.
                    if (fits) begin
                        r_s  <= trial;
                        r_lo <= r_lo | (16'd1 << r_bit);
                        r_e  <= (r_e >> 1) + r_d;
                    end else begin
                        r_e  <= r_e >> 1;
                    end
                    r_d <= r_d >> 2;
                    if (r_bit == 4'd0) begin
                        r_state <= C_OUT;
                    end else begin
                        r_bit <= r_bit - 4'd1;
                    end
                end
                C_OUT: begin
                    if (r_neg) begin
                        r_score <= -$signed(r_lo);
                    end else if (r_lo[15]) begin
                        r_score <= SIM_MAX;
                    end else begin
                        r_score <= $signed(r_lo);
                    end
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_score = r_score;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cosine best-match table. Templates and queries
// are streamed in as command beats, every result is compared field by field
// with a scoring model kept in the bench, and the threshold register is
// swept over the APB port between phases.
// ----------------------------------------------------------------------------
module tb;
    import cbm_pkg::*;

    localparam int DIM       = CBM_EMBED_DIM;
    localparam int ENTRIES   = CBM_MAX_ENTRIES;
    localparam int STALL_MAX = 200000;

    localparam logic [1:0] KIND_IGNORED = 2'd3;

    typedef enum int {
        FILL_RAND, FILL_SMALL, FILL_ZERO, FILL_COPY, FILL_NEG, FILL_POS_MAX, FILL_NEG_MAX,
        FILL_NEAR
    } t_fill;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       i_item;
    logic        o_done;
    t_result     o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cosine_best_match_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow copy of the table and of the query in progress.
    shortint         tmpl_mem [ENTRIES][DIM];
    logic [15:0]     label_mem [ENTRIES];
    longint unsigned tmpl_norm [ENTRIES];
    shortint         query_buf [DIM];
    longint unsigned query_norm;
    int              entry_count;
    int              elem_pos;
    int              threshold;

    t_result pending_results[$];
    t_result want;
    int      fail_count;
    int      results_seen;
    int      idle_pct;
    int      stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int cos_score(int slot);
        longint      dot;
        logic [63:0]  mag;
        logic [191:0] rhs;
        logic [191:0] den;
        logic [191:0] lhs;
        int           lo;
        int           hi;
        int           mid;
        if (query_norm == 0 || tmpl_norm[slot] == 0) return -32768;
        dot = 0;
        for (int i = 0; i < DIM; i++)
            dot += longint'(int'(query_buf[i]) * int'(tmpl_mem[slot][i]));
        mag = (dot < 0) ? 64'(-dot) : 64'(dot);
        rhs = (192'(mag) * 192'(mag)) << 30;
        den = 192'(query_norm) * 192'(tmpl_norm[slot]);
        lo = 0;
        hi = 32768;
        // Largest lo with lo^2 * |q|^2 * |t|^2 <= dot^2 * 2^30.
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            lhs = den * 192'(mid) * 192'(mid);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        if (dot >= 0) return (lo > 32767) ? 32767 : lo;
        return -lo;
    endfunction

    function automatic t_result make_result(logic [2:0] st, int ent, int lab, int sim);
        t_result r;
        r.status          = st;
        r.best_entry      = ENTRY_W'(ent);
        r.best_label      = LABEL_W'(lab);
        r.best_similarity = SIM_W'(sim);
        return r;
    endfunction

    function automatic void queue_result(t_result r);
        pending_results = {pending_results, r};
    endfunction

    // Updates the shadow table for one accepted beat and queues its result, if it gives one.
    task automatic track_beat(t_item it);
        int              pos;
        bit              length_ok;
        int              best;
        int              best_ent;
        int              best_lab;
        int              s;
        longint unsigned acc;
        pos = elem_pos;
        if (it.kind == KIND_IGNORED) return;
        if (it.kind == KIND_CLEAR) begin
            entry_count = 0;
            elem_pos = 0;
            return;
        end
        if (it.kind == KIND_TMPL) begin
            if (pos < DIM && entry_count < ENTRIES)
                tmpl_mem[entry_count][pos] = it.element_value;
        end else if (pos < DIM) begin
            query_buf[pos] = it.element_value;
        end
        if (!it.element_last) begin
            elem_pos = (pos < DIM) ? pos + 1 : DIM;
            return;
        end
        elem_pos = 0;
        length_ok = (pos == DIM - 1);
        if (it.kind == KIND_TMPL) begin
            if (!length_ok) begin
                queue_result(make_result(ST_BADLEN, 0, 0, -32768));
            end else if (entry_count >= ENTRIES) begin
                queue_result(make_result(ST_FULL, 0, 0, -32768));
            end else begin
                acc = 0;
                for (int i = 0; i < DIM; i++)
                    acc += longint'(int'(tmpl_mem[entry_count][i]) *
                                    int'(tmpl_mem[entry_count][i]));
                tmpl_norm[entry_count] = acc;
                label_mem[entry_count] = it.template_label;
                queue_result(make_result(ST_STORED, entry_count,
                                         it.template_label, -32768));
                entry_count++;
            end
            return;
        end
        acc = 0;
        if (length_ok)
            for (int i = 0; i < DIM; i++)
                acc += longint'(int'(query_buf[i]) * int'(query_buf[i]));
        query_norm = acc;
        best = -32768;
        best_ent = 0;
        best_lab = 0;
        if (length_ok) begin
            for (int e = 0; e < entry_count; e++) begin
                s = cos_score(e);
                if (s > best) begin
                    best = s;
                    best_ent = e;
                    best_lab = label_mem[e];
                end
            end
        end
        if (entry_count != 0 && best >= threshold)
            queue_result(make_result(ST_KNOWN, best_ent, best_lab, best));
        else
            queue_result(make_result(ST_UNKNOWN, best_ent, 0, best));
    endtask

    // Holds start until the beat is taken; each following cycle is then left
    // idle with the phase's probability.
    task automatic send_beat(t_item it);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        track_beat(it);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_single(logic [1:0] kind, bit last);
        t_item it;
        it.kind           = kind;
        it.element_value  = 16'($urandom);
        it.template_label = 16'($urandom);
        it.element_last   = last;
        send_beat(it);
    endtask

    function automatic shortint fill_value(t_fill mode, int idx, int src);
        shortint v;
        int      w;
        case (mode)
            FILL_SMALL:   return shortint'($urandom_range(0, 6)) - 16'sd3;
            FILL_ZERO:    return 16'sd0;
            FILL_COPY:    return tmpl_mem[src][idx % DIM];
            FILL_NEG: begin
                v = tmpl_mem[src][idx % DIM];
                return (v == -16'sd32768) ? 16'sd32767 : -v;
            end
            FILL_POS_MAX: return 16'sd32767;
            FILL_NEG_MAX: return -16'sd32768;
            FILL_NEAR: begin
                // A stored template with added noise, clipped to the element range.
                w = int'(tmpl_mem[src][idx % DIM]) + int'($urandom_range(0, 16000)) - 8000;
                if (w > 32767) w = 32767;
                if (w < -32768) w = -32768;
                return shortint'(w);
            end
            default:      return shortint'($urandom);
        endcase
    endfunction

    // One template or query of len beats; the label rides on the last beat.
    task automatic send_sequence(logic [1:0] kind, int len, logic [15:0] label,
                                 t_fill mode, int src);
        t_item it;
        for (int i = 0; i < len; i++) begin
            it.kind           = kind;
            it.element_value  = fill_value(mode, i, src);
            it.template_label = (i == len - 1) ? label : 16'($urandom);
            it.element_last   = (i == len - 1);
            send_beat(it);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_threshold(int value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_THRESHOLD, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        threshold = value;
    endtask

    task automatic test_empty_table();
        send_sequence(KIND_QUERY, 3, 16'h0, FILL_RAND, 0);
    endtask

    task automatic test_bad_lengths();
        send_sequence(KIND_TMPL, 1, 16'h5555, FILL_RAND, 0);
        send_sequence(KIND_TMPL, 5, 16'h5555, FILL_RAND, 0);
        send_sequence(KIND_QUERY, 5, 16'h0, FILL_RAND, 0);
        send_sequence(KIND_QUERY, 1, 16'h0, FILL_RAND, 0);
    endtask

    task automatic test_clear_and_ignored();
        send_single(KIND_IGNORED, 1'b1);
        send_single(KIND_IGNORED, 1'b0);
        for (int i = 0; i < 10; i++) send_single(KIND_TMPL, 1'b0);
        send_single(KIND_CLEAR, 1'b1);
        send_sequence(KIND_QUERY, 2, 16'h0, FILL_RAND, 0);
        send_single(KIND_IGNORED, 1'b1);
    endtask

    task automatic test_match_cases();
        send_single(KIND_CLEAR, 1'b0);
        send_sequence(KIND_TMPL, DIM, 16'hA5A5, FILL_RAND, 0);
        // A noisy copy of the stored template scores high but below +1.
        write_threshold(16000);
        send_sequence(KIND_QUERY, DIM, 16'h0, FILL_NEAR, 0);
    endtask

    task automatic test_thresholds();
        write_threshold(32767);
        send_sequence(KIND_QUERY, 4, 16'h0, FILL_RAND, 0);
        write_threshold(-32767);
        send_sequence(KIND_QUERY, 4, 16'h0, FILL_RAND, 0);
        write_threshold(0);
    endtask

    task automatic run_random_phase(int pct, int thr);
        int    goal;
        int    r;
        logic [1:0] kind;
        write_threshold(thr);
        idle_pct = pct;
        goal = results_seen + pending_results.size() + 5;
        send_single(KIND_CLEAR, 1'b0);
        while (results_seen + pending_results.size() < goal) begin
            r = $urandom_range(99);
            kind = $urandom_range(1) ? KIND_TMPL : KIND_QUERY;
            if (r < 10) begin
                send_single(KIND_CLEAR, $urandom_range(1));
            end else if (r < 20) begin
                send_single(KIND_IGNORED, $urandom_range(1));
            end else begin
                send_sequence(kind, $urandom_range(1, 6), 16'($urandom), FILL_RAND, 0);
            end
        end
    endtask

    task automatic test_random();
        run_random_phase(0, 0);
        run_random_phase(85, -32767);
        run_random_phase(0, 16000);
        run_random_phase(18, -1000);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_result);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_result.status);
                    fail_count++;
                end
                if (o_result.best_entry !== want.best_entry) begin
                    $display("%0t: best_entry expected %0d actual %0d",
                             $time, want.best_entry, o_result.best_entry);
                    fail_count++;
                end
                if (o_result.best_label !== want.best_label) begin
                    $display("%0t: best_label expected %h actual %h",
                             $time, want.best_label, o_result.best_label);
                    fail_count++;
                end
                if (o_result.best_similarity !== want.best_similarity) begin
                    $display("%0t: best_similarity expected %0d actual %0d",
                             $time, want.best_similarity, o_result.best_similarity);
                    fail_count++;
                end
            end
        end
    end

    // Ends the run when neither a beat nor a result moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_item       = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        stall_cycles = 0;
        fail_count   = 0;
        results_seen = 0;
        idle_pct     = 0;
        entry_count  = 0;
        elem_pos     = 0;
        query_norm   = 0;
        threshold    = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_bad_lengths();
        test_clear_and_ignored();
        test_match_cases();
        test_thresholds();
        test_random();

        start <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== cosine_best_match_table.f =====
src/cbm_pkg.sv
src/cbm_cfg.sv
src/cbm_score.sv
src/cosine_best_match_table.sv
tb/tb.sv
